@@ rtl/napf_pkg.sv @@
// ----------------------------------------------------------------------------
// napf_pkg: shared definitions of the neighbour angle point filter
// Sizes of the point and verdict lines, the digit-serial multiplier geometry,
// the point record and the state types of the sequencers.
// ----------------------------------------------------------------------------
package napf_pkg;

	localparam int MAX_LOOK = 16;
	localparam int PDEPTH   = MAX_LOOK + 2;
	localparam int ADEPTH   = 2 * MAX_LOOK + 1;
	localparam int IDX_CAP  = 2 * MAX_LOOK + 2;
	localparam int IDX_W    = 6;
	localparam int K_W      = 5;

	// Digit-serial multiplier: multiplicand up to MUL_AW bits, multiplier
	// MUL_BW bits consumed most significant digit first.
	localparam int DIG_W  = 4;
	localparam int MUL_AW = 132;
	localparam int MUL_BW = 68;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int MUL_CW = 5;

	// Configuration register indexes
	localparam logic CFG_LOOK = 1'b0;
	localparam logic CFG_COS  = 1'b1;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pt_t;

	typedef struct packed {
		logic              start;
		logic [MUL_CW-1:0] ndig;
	} mul_ctl_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_ISSUE,
		A_WAIT,
		A_DIFF,
		A_CMP
	} ang_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ANGLE,
		S_EMIT,
		S_MARK
	} top_state_t;

endpackage

@@ rtl/neighbor_angle_point_filter_unit.sv @@
// ----------------------------------------------------------------------------
// neighbor_angle_point_filter_unit: neighbour angle point filter
// Keeps the points of a scan whose neighbouring angles on one side are all
// wide enough, and closes each scan with an end marker.
//
//   channel  direction  handshake                payload
//   in       input      in_valid / in_stall      px py pz final_point
//   out      output     out_valid / out_stall    kx ky kz has_point run_end
//   cfg      input      cfg_valid / cfg_ready    cfg_index cfg_data
//
// One point at a time. The first two points of a scan skip the angle
// sequencer; every later point runs it on the digit-serial multiplier (nine
// 8-digit dot products, then, for vectors of nonzero length, a 17-digit
// square, a 17-digit product and one 8-digit scaling). Decisions run at one
// candidate point per cycle, at most eighteen, while no kept point waits on a
// stalled output, which holds its result; an end marker follows a final point.
// Reset clears the control state only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module neighbor_angle_point_filter_unit
	import napf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic               final_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] kx,
	output logic signed [31:0] ky,
	output logic signed [31:0] kz,
	output logic               has_point,
	output logic               run_end,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	top_state_t state_q, state_d;

	pt_t               pd_q [PDEPTH];
	logic [ADEPTH-1:0] okl_q;
	logic [IDX_W-1:0]  index_q;
	logic [IDX_W-1:0]  n_q;
	logic [K_W-1:0]    k_q, kmin_q;
	logic              fin_q;
	logic [4:0]        look_q;
	logic [15:0]       cos_q;
	logic              out_valid_q;
	logic              has_point_q, run_end_q;
	logic signed [31:0] kx_q, ky_q, kz_q;

	pt_t            pin;
	logic           accept;
	logic           ang_start, ang_done, ang_ok;
	logic [K_W-1:0] nl, nlp1, kmax;
	logic           slot_free;
	logic           skip, keep, fwd, bwd;
	logic           load_pt, load_mk, adv;
	logic [IDX_W-1:0] gap;

	function automatic logic all_ok(logic [ADEPTH-1:0] line, logic [K_W-1:0] from,
	                                logic [K_W-1:0] cnt);
		logic [ADEPTH-1:0] sh;
		logic [ADEPTH-1:0] m;
		sh = line >> from;
		m  = (ADEPTH'(1) << cnt) - ADEPTH'(1);
		return (sh & m) == m;
	endfunction

	assign pin.x     = px;
	assign pin.y     = py;
	assign pin.z     = pz;
	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign ang_start = accept && (index_q >= IDX_W'(2));
	assign slot_free = !out_valid_q || !out_stall;

	assign nl   = (look_q > K_W'(MAX_LOOK)) ? K_W'(MAX_LOOK) : look_q;
	assign nlp1 = nl + K_W'(1);
	assign kmax = (IDX_W'(nlp1) > index_q) ? K_W'(index_q) : nlp1;

	assign gap  = n_q - IDX_W'(k_q);
	assign skip = IDX_W'(k_q) > n_q;
	assign fwd  = (k_q == nlp1) && all_ok(okl_q, K_W'(0), nl);
	assign bwd  = (gap > IDX_W'(nl)) && all_ok(okl_q, k_q, nl);
	assign keep = !skip && (fwd || bwd);

	always_comb begin
		state_d = state_q;
		load_pt = 1'b0;
		load_mk = 1'b0;
		adv     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (index_q >= IDX_W'(2)) ? S_ANGLE : S_EMIT;
			end
			S_ANGLE: begin
				if (ang_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (keep) begin
					if (slot_free) begin
						load_pt = 1'b1;
						adv     = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
				if (adv && k_q == kmin_q) state_d = fin_q ? S_MARK : S_IDLE;
			end
			S_MARK: begin
				if (slot_free) begin
					load_mk = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			index_q     <= '0;
			look_q      <= 5'd3;
			cos_q       <= '0;
			out_valid_q <= 1'b0;
			okl_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_LOOK: look_q <= cfg_data[4:0];
					CFG_COS:  cos_q  <= cfg_data;
					default:  cos_q  <= cos_q;
				endcase
			end
			if (accept) begin
				if (final_point) index_q <= '0;
				else if (index_q < IDX_W'(IDX_CAP)) index_q <= index_q + IDX_W'(1);
			end
			if (state_q == S_ANGLE && ang_done) okl_q <= {okl_q[ADEPTH-2:0], ang_ok};
			if (load_pt || load_mk) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pd_q[0] <= pin;
			for (int i = 1; i < PDEPTH; i++) pd_q[i] <= pd_q[i-1];
			n_q    <= index_q;
			fin_q  <= final_point;
			k_q    <= final_point ? kmax : nlp1;
			kmin_q <= final_point ? K_W'(0) : nlp1;
		end else if (adv && k_q != kmin_q) begin
			k_q <= k_q - K_W'(1);
		end
		if (load_pt || load_mk) begin
			kx_q        <= load_pt ? pd_q[k_q].x : 32'sd0;
			ky_q        <= load_pt ? pd_q[k_q].y : 32'sd0;
			kz_q        <= load_pt ? pd_q[k_q].z : 32'sd0;
			has_point_q <= load_pt;
			run_end_q   <= load_mk;
		end
	end

	napf_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ang_start),
		.p_new     (pin),
		.p_mid     (pd_q[0]),
		.p_old     (pd_q[1]),
		.cos_limit (cos_q),
		.done      (ang_done),
		.ok        (ang_ok)
	);

	assign out_valid = out_valid_q;
	assign kx        = kx_q;
	assign ky        = ky_q;
	assign kz        = kz_q;
	assign has_point = has_point_q;
	assign run_end   = run_end_q;

endmodule

@@ rtl/napf_mul.sv @@
// ----------------------------------------------------------------------------
// napf_mul: digit-serial multiplier
// Multiplies an unsigned operand by a left-aligned unsigned operand, four
// multiplier bits per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module napf_mul
	import napf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mul_ctl_t          ctl,
	input  logic [MUL_AW-1:0] opa,
	input  logic [MUL_BW-1:0] opb,
	output logic              done,
	output logic [MUL_PW-1:0] prod
);

	logic [MUL_AW-1:0]       a_q;
	logic [MUL_BW-1:0]       b_q;
	logic [MUL_PW-1:0]       acc_q;
	logic [MUL_CW-1:0]       cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [MUL_AW+DIG_W-1:0] part;
	logic [MUL_PW-1:0]       acc_next;

	assign part     = a_q * (MUL_AW+DIG_W)'(b_q[MUL_BW-1 -: DIG_W]);
	assign acc_next = {acc_q[MUL_PW-DIG_W-1:0], {DIG_W{1'b0}}} + MUL_PW'(part);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.ndig;
		end else if (busy_q) begin
			cnt_q <= cnt_q - MUL_CW'(1);
			if (cnt_q == MUL_CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= opa;
			b_q   <= opb;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q   <= {b_q[MUL_BW-DIG_W-1:0], {DIG_W{1'b0}}};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ rtl/napf_angle.sv @@
// ----------------------------------------------------------------------------
// napf_angle: angle verdict sequencer
// Forms the neighbour vectors of the middle point and decides, through a
// chain of products on the shared digit-serial multiplier, whether the
// cosine of the angle is at or below the limit or a vector is all zero.
// ----------------------------------------------------------------------------
module napf_angle
	import napf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pt_t                p_new,
	input  pt_t                p_mid,
	input  pt_t                p_old,
	input  logic signed [15:0] cos_limit,
	output logic               done,
	output logic               ok
);

	localparam logic [3:0] OP_LAST_DOT = 4'd8;
	localparam logic [3:0] OP_D2       = 4'd9;
	localparam logic [3:0] OP_AB       = 4'd10;
	localparam logic [3:0] OP_R        = 4'd11;
	localparam logic [1:0] T_UU        = 2'd0;
	localparam logic [1:0] T_VV        = 2'd1;
	localparam logic [1:0] T_UV        = 2'd2;

	ang_state_t state_q, state_d;

	logic [31:0]  co_new [3];
	logic [31:0]  co_mid [3];
	logic [31:0]  co_old [3];
	logic [32:0]  du     [3];
	logic [32:0]  dv     [3];
	logic [32:0]  nu     [3];
	logic [32:0]  nv     [3];
	logic [31:0]  um_q   [3];
	logic [31:0]  vm_q   [3];
	logic         sn_q   [3];
	logic [65:0]  a_q, b_q, dp_q, dn_q, d_q;
	logic [131:0] d2_q, ab_q;
	logic [161:0] rhs_q;
	logic [161:0] lhs;
	logic         pos_q, ge_q;
	logic [3:0]   op_q;
	logic [1:0]   ax;
	logic [1:0]   term;
	logic [15:0]  lm;
	logic [31:0]  lm2;
	logic         zero_len;
	logic         above;

	mul_ctl_t          mctl;
	logic              mul_start;
	logic [MUL_CW-1:0] mul_ndig;
	logic [MUL_AW-1:0] opa;
	logic [MUL_BW-1:0] opb;
	logic              mdone;
	logic [MUL_PW-1:0] prod;

	assign co_new[0] = p_new.x;
	assign co_new[1] = p_new.y;
	assign co_new[2] = p_new.z;
	assign co_mid[0] = p_mid.x;
	assign co_mid[1] = p_mid.y;
	assign co_mid[2] = p_mid.z;
	assign co_old[0] = p_old.x;
	assign co_old[1] = p_old.y;
	assign co_old[2] = p_old.z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			du[i] = {co_old[i][31], co_old[i]} - {co_mid[i][31], co_mid[i]};
			dv[i] = {co_new[i][31], co_new[i]} - {co_mid[i][31], co_mid[i]};
			nu[i] = 33'd0 - du[i];
			nv[i] = 33'd0 - dv[i];
		end
	end

	assign lm  = cos_limit[15] ? 16'(-cos_limit) : 16'(cos_limit);
	assign lm2 = lm * lm;

	// Operand selection for the current product
	always_comb begin
		unique case (op_q)
			4'd0:    begin ax = 2'd0; term = T_UU; end
			4'd1:    begin ax = 2'd0; term = T_VV; end
			4'd2:    begin ax = 2'd0; term = T_UV; end
			4'd3:    begin ax = 2'd1; term = T_UU; end
			4'd4:    begin ax = 2'd1; term = T_VV; end
			4'd5:    begin ax = 2'd1; term = T_UV; end
			4'd6:    begin ax = 2'd2; term = T_UU; end
			4'd7:    begin ax = 2'd2; term = T_VV; end
			4'd8:    begin ax = 2'd2; term = T_UV; end
			default: begin ax = 2'd0; term = T_UU; end
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_D2: begin
				opa      = MUL_AW'(d_q);
				opb      = MUL_BW'(d_q);
				mul_ndig = MUL_CW'(MUL_BW / DIG_W);
			end
			OP_AB: begin
				opa      = MUL_AW'(a_q);
				opb      = MUL_BW'(b_q);
				mul_ndig = MUL_CW'(MUL_BW / DIG_W);
			end
			OP_R: begin
				opa      = ab_q;
				opb      = {lm2, {(MUL_BW-32){1'b0}}};
				mul_ndig = MUL_CW'(32 / DIG_W);
			end
			default: begin
				opa      = MUL_AW'((term == T_VV) ? vm_q[ax] : um_q[ax]);
				opb      = {((term == T_UU) ? um_q[ax] : vm_q[ax]), {(MUL_BW-32){1'b0}}};
				mul_ndig = MUL_CW'(32 / DIG_W);
			end
		endcase
	end

	assign mctl = {mul_start, mul_ndig};

	assign zero_len = (a_q == '0) || (b_q == '0);
	assign lhs      = {2'b00, d2_q, 28'd0};
	// With a negative limit the angle is too narrow when the dot product is
	// not negative or its scaled square falls short of the bound.
	assign above    = cos_limit[15] ? (ge_q || (lhs < rhs_q)) : (pos_q && (lhs > rhs_q));

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		done      = 1'b0;
		ok        = 1'b0;
		unique case (state_q)
			A_IDLE: begin
				if (start) state_d = A_ISSUE;
			end
			A_ISSUE: begin
				mul_start = 1'b1;
				state_d   = A_WAIT;
			end
			A_WAIT: begin
				if (mdone) begin
					if (op_q == OP_LAST_DOT) state_d = A_DIFF;
					else if (op_q == OP_R) state_d = A_CMP;
					else state_d = A_ISSUE;
				end
			end
			A_DIFF: begin
				if (zero_len) begin
					done    = 1'b1;
					ok      = 1'b1;
					state_d = A_IDLE;
				end else begin
					state_d = A_ISSUE;
				end
			end
			A_CMP: begin
				done    = 1'b1;
				ok      = !above;
				state_d = A_IDLE;
			end
			default: state_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= A_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && start) begin
			for (int i = 0; i < 3; i++) begin
				um_q[i] <= du[i][32] ? nu[i][31:0] : du[i][31:0];
				vm_q[i] <= dv[i][32] ? nv[i][31:0] : dv[i][31:0];
				sn_q[i] <= du[i][32] ^ dv[i][32];
			end
			a_q  <= '0;
			b_q  <= '0;
			dp_q <= '0;
			dn_q <= '0;
			op_q <= '0;
		end else if (state_q == A_WAIT && mdone) begin
			unique case (op_q)
				OP_D2: d2_q <= prod[131:0];
				OP_AB: ab_q <= prod[131:0];
				OP_R:  rhs_q <= prod[161:0];
				default: begin
					if (term == T_UU) a_q <= a_q + 66'(prod[63:0]);
					else if (term == T_VV) b_q <= b_q + 66'(prod[63:0]);
					else if (sn_q[ax]) dn_q <= dn_q + 66'(prod[63:0]);
					else dp_q <= dp_q + 66'(prod[63:0]);
				end
			endcase
			if (op_q != OP_LAST_DOT && op_q != OP_R) op_q <= op_q + 4'd1;
		end else if (state_q == A_DIFF) begin
			d_q   <= (dp_q > dn_q) ? (dp_q - dn_q) : (dn_q - dp_q);
			pos_q <= dp_q > dn_q;
			ge_q  <= dp_q >= dn_q;
			op_q  <= OP_D2;
		end
	end

	napf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.opa    (opa),
		.opb    (opb),
		.done   (mdone),
		.prod   (prod)
	);

endmodule
